// ===== rtl/crre_pkg.sv =====
// Shared types and codes for the CAN request retry engine.
`default_nettype none

package crre_pkg;

    // Input opcodes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_FRAME = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_SEND    = 2'd0;
    localparam logic [1:0] KIND_SUCCESS = 2'd1;
    localparam logic [1:0] KIND_FAIL    = 2'd2;

    // Failure reasons
    localparam logic [1:0] FAIL_NO_DEVICE     = 2'd0;
    localparam logic [1:0] FAIL_NOT_CONNECTED = 2'd1;
    localparam logic [1:0] FAIL_TIMEOUT       = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_REQUEST_ID    = 2'd0;
    localparam logic [1:0] CFG_RESPONSE_ID   = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT_TICKS = 2'd2;
    localparam logic [1:0] CFG_MAX_RETRIES   = 2'd3;

    // Register reset values
    localparam logic [15:0] TIMEOUT_RESET = 16'd100;
    localparam logic [7:0]  RETRIES_RESET = 8'd3;

    // Longest CAN data field in bytes
    localparam logic [3:0] MAX_RX_BYTES = 4'd8;
    localparam int         REPLY_BYTES  = 7;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [5:0]  request_code;
        logic        device_present;
        logic        bus_connected;
        logic [28:0] rx_frame_id;
        logic [3:0]  rx_length;
        logic [63:0] rx_payload;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  kind;
        logic [28:0] tx_frame_id;
        logic [7:0]  tx_tag;
        logic [55:0] reply_data;
        logic [2:0]  reply_length;
        logic [1:0]  fail_reason;
    } t_out_word;

    typedef struct packed {
        logic [28:0] request_id;
        logic [28:0] response_id;
        logic [15:0] timeout_ticks;
        logic [7:0]  max_retries;
    } t_cfg;

    // Decoded command passed from front to back
    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_FRAME = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef struct packed {
        t_cmd        cmd;
        logic [5:0]  code;
        logic        present;
        logic        connected;
        logic        id_ok;
        logic        len_ok;
        logic [7:0]  first_byte;
        logic [2:0]  reply_length;
        logic [55:0] reply_data;
    } t_cls;

endpackage

`default_nettype wire

// ===== rtl/crre_fifo.sv =====
// Small flip-flop queue between the classifier and the sequencer.
`default_nettype none

module crre_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [AW:0]      r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointer and fill bookkeeping, pointers wrap at the last entry
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        n_count  = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/crre_front.sv =====
// Input side: accepts words and classifies them for the sequencer.
`default_nettype none

module crre_front (
    input  wire logic               i_in_valid,
    input  wire crre_pkg::t_in_word i_in_word,
    output logic                    o_in_stall,
    input  wire crre_pkg::t_cfg     i_cfg,
    input  wire logic               i_q_full,
    output logic                    o_push,
    output crre_pkg::t_cls          o_cls
);
    import crre_pkg::*;

    logic [3:0] len_c;
    logic [2:0] rlen;

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // Clamp length to a full CAN frame, reply excludes the tag byte
    assign len_c = (i_in_word.rx_length > MAX_RX_BYTES) ? MAX_RX_BYTES : i_in_word.rx_length;
    assign rlen  = 3'(len_c - 4'd1);

    always_comb begin
        o_cls            = '0;
        o_cls.code       = i_in_word.request_code;
        o_cls.present    = i_in_word.device_present;
        o_cls.connected  = i_in_word.bus_connected;
        o_cls.id_ok      = (i_in_word.rx_frame_id == i_cfg.response_id);
        o_cls.len_ok     = (len_c != 4'd0);
        o_cls.first_byte = i_in_word.rx_payload[7:0];
        o_cls.reply_length = rlen;

        case (i_in_word.opcode)
            OP_START: o_cls.cmd = CMD_START;
            OP_FRAME: o_cls.cmd = CMD_FRAME;
            OP_TICK:  o_cls.cmd = CMD_TICK;
            default:  o_cls.cmd = CMD_NONE;
        endcase

        // Keep only the bytes covered by the received length
        for (int b = 0; b < REPLY_BYTES; b++) begin
            if (3'(b) < rlen) begin
                o_cls.reply_data[8*b +: 8] = i_in_word.rx_payload[8*b+8 +: 8];
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/crre_back.sv =====
// Sequencer: request state, retries, timeout and the output register.
`default_nettype none

module crre_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire crre_pkg::t_cfg i_cfg,
    input  wire logic           i_q_valid,
    input  wire crre_pkg::t_cls i_q_word,
    output logic                o_q_pop,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output crre_pkg::t_out_word o_out_word
);
    import crre_pkg::*;

    logic        r_waiting, n_waiting;
    logic [5:0]  r_code, n_code;
    logic [7:0]  r_retry, n_retry;
    logic [15:0] r_timer, n_timer;
    logic        r_out_valid;
    t_out_word   r_out_word;

    logic        can_load;
    logic        res_valid;
    t_out_word   res;
    logic [7:0]  retry_inc;
    logic [15:0] timer_inc;
    logic [7:0]  cur_tag;

    assign can_load  = !r_out_valid || !i_out_stall;
    assign o_q_pop   = i_q_valid && can_load;
    assign retry_inc = r_retry + 8'd1;
    assign timer_inc = r_timer + 16'd1;
    assign cur_tag   = {r_code, r_retry[1:0]};

    // Per-word state update
    always_comb begin
        n_waiting = r_waiting;
        n_code    = r_code;
        n_retry   = r_retry;
        n_timer   = r_timer;
        res_valid = 1'b0;
        res       = '0;

        if (o_q_pop) begin
            case (i_q_word.cmd)
                CMD_START: begin
                    n_waiting = 1'b0;
                    res_valid = 1'b1;
                    if (!i_q_word.present) begin
                        res.kind        = KIND_FAIL;
                        res.fail_reason = FAIL_NO_DEVICE;
                    end else if (!i_q_word.connected) begin
                        res.kind        = KIND_FAIL;
                        res.fail_reason = FAIL_NOT_CONNECTED;
                    end else begin
                        n_code          = i_q_word.code;
                        n_retry         = '0;
                        n_timer         = '0;
                        n_waiting       = 1'b1;
                        res.kind        = KIND_SEND;
                        res.tx_frame_id = i_cfg.request_id;
                        res.tx_tag      = {i_q_word.code, 2'b00};
                    end
                end
                CMD_FRAME: begin
                    if (r_waiting) begin
                        res_valid = 1'b1;
                        if (i_q_word.id_ok && i_q_word.len_ok &&
                            (i_q_word.first_byte == cur_tag)) begin
                            n_waiting        = 1'b0;
                            res.kind         = KIND_SUCCESS;
                            res.reply_data   = i_q_word.reply_data;
                            res.reply_length = i_q_word.reply_length;
                        end else if (r_retry >= i_cfg.max_retries) begin
                            n_waiting       = 1'b0;
                            res.kind        = KIND_FAIL;
                            res.fail_reason = FAIL_TIMEOUT;
                        end else begin
                            // resend with the next tag
                            n_retry         = retry_inc;
                            n_timer         = '0;
                            res.kind        = KIND_SEND;
                            res.tx_frame_id = i_cfg.request_id;
                            res.tx_tag      = {r_code, retry_inc[1:0]};
                        end
                    end
                end
                CMD_TICK: begin
                    if (r_waiting) begin
                        n_timer = timer_inc;
                        if (timer_inc >= i_cfg.timeout_ticks) begin
                            n_waiting       = 1'b0;
                            res_valid       = 1'b1;
                            res.kind        = KIND_FAIL;
                            res.fail_reason = FAIL_TIMEOUT;
                        end
                    end
                end
                default: begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waiting   <= 1'b0;
            r_code      <= '0;
            r_retry     <= '0;
            r_timer     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_waiting <= n_waiting;
            r_code    <= n_code;
            r_retry   <= n_retry;
            r_timer   <= n_timer;
            if (can_load) begin
                r_out_valid <= res_valid;
            end
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (can_load && res_valid) begin
            r_out_word <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

// ===== rtl/can_request_retry_engine.sv =====
// CAN request engine with retries: top level, configuration registers and wiring.
//
// Input channel (i_in_valid / o_in_stall / i_in_word) carries start, received
// frame and tick words. Output channel (o_out_valid / i_out_stall / o_out_word)
// carries send-request, success and failure words; a word yields zero or one.
// Configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data):
// 0 request_id, 1 response_id, 2 timeout_ticks, 3 max_retries.
// Throughput: one input word per cycle while o_in_stall is low. A front
// classifier pushes each word into a QUEUE_DEPTH entry queue; the sequencer
// pops one word a cycle, while the output register is free, into a single
// output register. A result is registered there as its word is popped from the queue.
// When the receiver stalls, the output register holds; the sequencer stops
// popping, and once the queue fills o_in_stall rises.
// Reset (synchronous, active low) empties the queue and output register,
// returns to idle and loads register defaults (timeout 100, retries 3).
`default_nettype none

module can_request_retry_engine #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire crre_pkg::t_in_word i_in_word,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output crre_pkg::t_out_word     o_out_word,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [28:0]        i_cfg_data
);
    import crre_pkg::*;

    localparam int CLS_W = $bits(t_cls);

    t_cfg       r_cfg;
    logic       q_full, q_push, q_pop, q_valid;
    t_cls       front_cls;
    logic [CLS_W-1:0] q_data;
    t_cls       q_word;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.request_id    <= '0;
            r_cfg.response_id   <= '0;
            r_cfg.timeout_ticks <= TIMEOUT_RESET;
            r_cfg.max_retries   <= RETRIES_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_REQUEST_ID:    r_cfg.request_id    <= i_cfg_data;
                CFG_RESPONSE_ID:   r_cfg.response_id   <= i_cfg_data;
                CFG_TIMEOUT_TICKS: r_cfg.timeout_ticks <= i_cfg_data[15:0];
                CFG_MAX_RETRIES:   r_cfg.max_retries   <= i_cfg_data[7:0];
                default:           r_cfg               <= r_cfg;
            endcase
        end
    end

    crre_front u_front (
        .i_in_valid (i_in_valid),
        .i_in_word  (i_in_word),
        .o_in_stall (o_in_stall),
        .i_cfg      (r_cfg),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_cls      (front_cls)
    );

    crre_fifo #(
        .WIDTH (CLS_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_cls),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data)
    );

    assign q_word = t_cls'(q_data);

    crre_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (q_valid),
        .i_q_word    (q_word),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire
